/* sv/bmp24_to_framebuffer_unit_defines.svh */
// Assertion macros of the BMP decoder RTL, used by the back end.
`ifndef BMP24_TO_FRAMEBUFFER_UNIT_DEFINES_SVH
`define BMP24_TO_FRAMEBUFFER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/b2fb_pkg.sv */
// Types and constants of the BMP decoder.
`default_nettype none
package b2fb_pkg;

  typedef enum logic [2:0] {
    KIND_PIXEL    = 3'd0,
    KIND_DONE     = 3'd1,
    KIND_BADSIG   = 3'd2,
    KIND_BADDEPTH = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_LARGE    = 3'd5
  } b2fb_kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_PAD    = 2'd2,
    PH_IDLE   = 2'd3
  } b2fb_phase_e;

  localparam logic [5:0]  HDR_SIG0  = 6'd0;
  localparam logic [5:0]  HDR_SIG1  = 6'd1;
  localparam logic [5:0]  HDR_W0    = 6'd18;
  localparam logic [5:0]  HDR_H0    = 6'd22;
  localparam logic [5:0]  HDR_D0    = 6'd28;
  localparam logic [5:0]  HDR_LAST  = 6'd53;

  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [15:0] DEPTH_24  = 16'd24;
  localparam logic [7:0]  ALPHA     = 8'hFF;

  localparam logic        CFG_X_OFFSET = 1'b0;
  localparam logic        CFG_Y_OFFSET = 1'b1;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned ADDR_W     = 19;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic               pix_vld;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [23:0]        rgb;
    logic               rep_vld;
    b2fb_kind_e         rep_kind;
  } b2fb_cmd_t;

endpackage
`default_nettype wire

/* sv/b2fb_if.sv */
// Handshake channels of the BMP decoder: file bytes, results and register writes.
`default_nettype none
interface b2fb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, first_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, first_byte, end_of_file, output ready);
endinterface

interface b2fb_res_if import b2fb_pkg::*; ;
  logic        valid;
  logic        ready;
  b2fb_kind_e  kind;
  logic [18:0] pixel_address;
  logic [31:0] pixel_value;
  logic        last_of_run;
  modport source (output valid, kind, pixel_address, pixel_value, last_of_run, input ready);
  modport sink   (input valid, kind, pixel_address, pixel_value, last_of_run, output ready);
endinterface

interface b2fb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/b2fb_front.sv */
// Front end: header parser, pixel grouping, row walk and clipping.
`default_nettype none
module b2fb_front import b2fb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 800,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  b2fb_byte_if.sink   byte_i,
  b2fb_cfg_if.sink    cfg_i,
  input  wire         q_full_i,
  output logic        push_o,
  output b2fb_cmd_t   cmd_o
);

  b2fb_phase_e ph_q, ph_d;
  logic [5:0]  hc_q, hc_d;
  logic [31:0] w_q, w_d, h_q, h_d;
  logic [15:0] dep_q, dep_d;
  logic [15:0] col_q, col_d, row_q, row_d;
  logic [1:0]  bip_q, bip_d;
  logic [15:0] held_q, held_d;
  logic [1:0]  pad_q, pad_d;
  logic        sig_q, sig_d;
  logic [15:0] xoff_q, yoff_q;

  b2fb_phase_e ph;
  logic [5:0]  hc;
  logic [31:0] w, h;
  logic [15:0] dep, col, row, held;
  logic [1:0]  bip, pad;
  logic        sig;
  logic        accept, stop, img_done;
  logic [17:0] xs, ys;
  logic [15:0] yrow;
  logic [16:0] col_next, row_next;
  logic        row_last, in_screen;
  logic [1:0]  pad_next;

  assign byte_i.ready = !q_full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    if (byte_i.first_byte) begin
      ph = PH_HEADER; hc = '0; w = '0; h = '0; dep = '0; col = '0; row = '0;
      bip = '0; held = '0; pad = '0; sig = 1'b0;
    end else begin
      ph = ph_q; hc = hc_q; w = w_q; h = h_q; dep = dep_q; col = col_q; row = row_q;
      bip = bip_q; held = held_q; pad = pad_q; sig = sig_q;
    end
  end

  always_comb begin
    xs        = {{2{xoff_q[15]}}, xoff_q} + {2'b00, col};
    yrow      = h[15:0] - 16'd1 - row;
    ys        = {{2{yoff_q[15]}}, yoff_q} + {2'b00, yrow};
    in_screen = !xs[17] && (xs[16:0] < 17'(SCREEN_WIDTH)) &&
                !ys[17] && (ys[16:0] < 17'(SCREEN_HEIGHT));
    col_next  = {1'b0, col} + 17'd1;
    row_next  = {1'b0, row} + 17'd1;
    row_last  = row_next >= h[16:0];
    pad_next  = (pad != 2'd0) ? pad - 2'd1 : 2'd0;
  end

  always_comb begin
    ph_d = ph; hc_d = hc; w_d = w; h_d = h; dep_d = dep; col_d = col; row_d = row;
    bip_d = bip; held_d = held; pad_d = pad; sig_d = sig;
    stop     = 1'b0;
    img_done = 1'b0;
    cmd_o    = '0;
    cmd_o.rep_kind = KIND_DONE;
    case (ph)
      PH_HEADER: begin
        case (hc)
          HDR_SIG0:         sig_d = (byte_i.data_byte == SIG_B);
          HDR_SIG1:         sig_d = sig && (byte_i.data_byte == SIG_M);
          HDR_W0:           w_d[7:0]   = w[7:0]   | byte_i.data_byte;
          HDR_W0 + 6'd1:    w_d[15:8]  = w[15:8]  | byte_i.data_byte;
          HDR_W0 + 6'd2:    w_d[23:16] = w[23:16] | byte_i.data_byte;
          HDR_W0 + 6'd3:    w_d[31:24] = w[31:24] | byte_i.data_byte;
          HDR_H0:           h_d[7:0]   = h[7:0]   | byte_i.data_byte;
          HDR_H0 + 6'd1:    h_d[15:8]  = h[15:8]  | byte_i.data_byte;
          HDR_H0 + 6'd2:    h_d[23:16] = h[23:16] | byte_i.data_byte;
          HDR_H0 + 6'd3:    h_d[31:24] = h[31:24] | byte_i.data_byte;
          HDR_D0:           dep_d[7:0]  = dep[7:0]  | byte_i.data_byte;
          HDR_D0 + 6'd1:    dep_d[15:8] = dep[15:8] | byte_i.data_byte;
          default: ;
        endcase
        hc_d = hc + 6'd1;
        if (hc == HDR_LAST) begin
          stop  = 1'b1;
          ph_d  = PH_IDLE;
          cmd_o.rep_vld = 1'b1;
          if (!sig) begin
            cmd_o.rep_kind = KIND_BADSIG;
          end else if (dep != DEPTH_24) begin
            cmd_o.rep_kind = KIND_BADDEPTH;
          end else if (w[31] || (w == '0) || h[31] || (h == '0)) begin
            cmd_o.rep_kind = KIND_DONE;
          end else if ((w[31:16] != '0) || (h[31:16] != '0)) begin
            cmd_o.rep_kind = KIND_LARGE;
          end else begin
            stop  = 1'b0;
            ph_d  = PH_PIXEL;
            cmd_o.rep_vld = 1'b0;
          end
        end
      end
      PH_PIXEL: begin
        case (bip)
          2'd0: begin
            held_d = {8'h00, byte_i.data_byte};
            bip_d  = 2'd1;
          end
          2'd1: begin
            held_d[15:8] = byte_i.data_byte;
            bip_d        = 2'd2;
          end
          default: begin
            bip_d         = 2'd0;
            cmd_o.pix_vld = in_screen;
            cmd_o.x       = xs[COORD_W-1:0];
            cmd_o.y       = ys[COORD_W-1:0];
            cmd_o.rgb     = {byte_i.data_byte, held};
            if (col_next >= w[16:0]) begin
              col_d = '0;
              if (w[1:0] != 2'd0) begin
                pad_d = w[1:0];
                ph_d  = PH_PAD;
              end else begin
                row_d    = row_next[15:0];
                img_done = row_last;
                ph_d     = row_last ? PH_IDLE : PH_PIXEL;
              end
            end else begin
              col_d = col_next[15:0];
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_d = pad_next;
        if (pad_next == 2'd0) begin
          row_d    = row_next[15:0];
          img_done = row_last;
          ph_d     = row_last ? PH_IDLE : PH_PIXEL;
        end
      end
      default: ;
    endcase
    if (ph != PH_IDLE) begin
      if (img_done) begin
        cmd_o.rep_vld  = 1'b1;
        cmd_o.rep_kind = KIND_DONE;
      end else if (byte_i.end_of_file && !stop) begin
        cmd_o.rep_vld  = 1'b1;
        cmd_o.rep_kind = KIND_TRUNC;
        ph_d           = PH_IDLE;
      end
    end
  end

  assign push_o = accept && (cmd_o.pix_vld || cmd_o.rep_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEADER; hc_q <= '0; w_q <= '0; h_q <= '0; dep_q <= '0;
      col_q <= '0; row_q <= '0; bip_q <= '0; held_q <= '0; pad_q <= '0; sig_q <= 1'b0;
    end else if (accept) begin
      ph_q <= ph_d; hc_q <= hc_d; w_q <= w_d; h_q <= h_d; dep_q <= dep_d;
      col_q <= col_d; row_q <= row_d; bip_q <= bip_d; held_q <= held_d;
      pad_q <= pad_d; sig_q <= sig_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xoff_q <= '0;
      yoff_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_X_OFFSET: xoff_q <= cfg_i.data;
        CFG_Y_OFFSET: yoff_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/b2fb_fifo.sv */
// Command queue between the parser and the result sequencer.
`default_nettype none
module b2fb_fifo import b2fb_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  b2fb_cmd_t  cmd_i,
  output logic       full_o,
  input  wire        pop_i,
  output logic       vld_o,
  output b2fb_cmd_t  cmd_o
);

  b2fb_cmd_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign cmd_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/b2fb_back.sv */
// Back end: address generation and result beats, pixel write before report.
`default_nettype none
`include "bmp24_to_framebuffer_unit_defines.svh"
module b2fb_back import b2fb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = 800
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_vld_i,
  input  b2fb_cmd_t   q_cmd_i,
  output logic        pop_o,
  b2fb_res_if.source  res_o
);

  b2fb_cmd_t         cur_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              cur_vld_q, pix_pend_q;
  logic              fire, cur_done;

  assign fire     = res_o.valid && res_o.ready;
  assign cur_done = fire && (!pix_pend_q || !cur_q.rep_vld);
  assign pop_o    = q_vld_i && (!cur_vld_q || cur_done);
  assign addr_d   = ADDR_W'(q_cmd_i.y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(q_cmd_i.x);

  assign res_o.valid         = cur_vld_q;
  assign res_o.kind          = pix_pend_q ? KIND_PIXEL : cur_q.rep_kind;
  assign res_o.pixel_address = pix_pend_q ? addr_q : '0;
  assign res_o.pixel_value   = pix_pend_q ? {ALPHA, cur_q.rgb} : '0;
  assign res_o.last_of_run   = pix_pend_q ? !cur_q.rep_vld : 1'b1;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= q_cmd_i;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= 1'b0;
      pix_pend_q <= 1'b0;
    end else if (pop_o) begin
      cur_vld_q  <= 1'b1;
      pix_pend_q <= q_cmd_i.pix_vld;
    end else if (cur_done) begin
      cur_vld_q  <= 1'b0;
      pix_pend_q <= 1'b0;
    end else if (fire) begin
      pix_pend_q <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_rep_follows_pix, clk_i, rst_ni, fire && pix_pend_q && cur_q.rep_vld, res_o.valid && !pix_pend_q)
  `ASSERT_IMPLIES(a_cur_has_beat, clk_i, rst_ni, cur_vld_q, pix_pend_q || cur_q.rep_vld)
  `ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, pop_o, q_cmd_i.pix_vld || q_cmd_i.rep_vld)

endmodule
`default_nettype wire

/* sv/bmp24_to_framebuffer_unit.sv */
// Top level of the streaming 24-bit BMP to framebuffer decoder.
// A taken byte goes through the command queue into the back end's result register.
// Throughput: one byte per cycle while the command queue is not full; one result
// beat per cycle while res_o is ready, a byte with a pixel write and a report
// needing two beats; a four-entry command queue absorbs bursts.
// Reset: asynchronous, active low; parser back to header, offsets zero, queue empty.
`default_nettype none
module bmp24_to_framebuffer_unit import b2fb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 800,
  parameter int unsigned SCREEN_HEIGHT = 480
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  b2fb_byte_if.sink   byte_i,
  b2fb_cfg_if.sink    cfg_i,
  b2fb_res_if.source  res_o
);

  logic      push, full, pop, q_vld;
  b2fb_cmd_t push_cmd, head_cmd;

  b2fb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  b2fb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .cmd_o  (head_cmd)
  );

  b2fb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_vld_i (q_vld),
    .q_cmd_i (head_cmd),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

/* verif/tb_bmp24_to_framebuffer_unit.sv */
// Self-checking testbench of the 24-bit BMP decoder: files in, framebuffer beats checked.
`timescale 1ns / 1ps
module tb_bmp24_to_framebuffer_unit;
  import b2fb_pkg::*;

  localparam int SCR_W       = 800;
  localparam int SCR_H       = 480;
  localparam int HDR_BYTES   = HDR_LAST + 1;
  localparam int STALL_LIMIT = 1000;
  localparam int BYTE_BUDGET = 980;

  typedef struct packed {
    b2fb_kind_e  kind;
    logic [18:0] addr;
    logic [31:0] value;
    logic        last;
  } fb_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  b2fb_byte_if byte_if ();
  b2fb_cfg_if  cfg_if ();
  b2fb_res_if  res_if ();

  bmp24_to_framebuffer_unit #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .byte_i(byte_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder state as seen from outside
  b2fb_phase_e dec_phase;
  int          hdr_idx;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [15:0] img_depth;
  int unsigned col_idx;
  int unsigned row_idx;
  int          pix_byte;
  logic [15:0] held_bg;
  int unsigned pad_cnt;
  bit          sig_good;
  int          x_off;
  int          y_off;

  fb_beat_t fb_q[$];
  fb_beat_t head_beat;
  int       err_count;
  int       bytes_used;
  int       gap_pct;
  bit       stalls_on;
  int       stall_left;
  int       idle_cycles;

  function automatic fb_beat_t beat_of(b2fb_kind_e k, logic [18:0] a, logic [31:0] v);
    fb_beat_t r;
    r.kind  = k;
    r.addr  = a;
    r.value = v;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void clear_parser();
    dec_phase = PH_HEADER;
    hdr_idx   = 0;
    img_w     = '0;
    img_h     = '0;
    img_depth = '0;
    col_idx   = 0;
    row_idx   = 0;
    pix_byte  = 0;
    held_bg   = '0;
    pad_cnt   = 0;
    sig_good  = 1'b0;
  endfunction

  function automatic bit close_row();
    row_idx++;
    if (row_idx >= img_h) begin
      dec_phase = PH_IDLE;
      return 1'b1;
    end
    dec_phase = PH_PIXEL;
    return 1'b0;
  endfunction

  function automatic int image_bytes(int unsigned w, int unsigned h);
    return HDR_BYTES + h * (((w * 24 + 31) / 32) * 4);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic first, input logic eof);
    fb_beat_t    outs[$];
    bit          fin;
    int          xs;
    int          ys;
    int unsigned pad;
    logic [18:0] addr;
    fin = 1'b0;
    if (first) clear_parser();
    if (dec_phase == PH_IDLE) return;
    if (dec_phase == PH_HEADER) begin
      if (hdr_idx == HDR_SIG0) sig_good = (b == SIG_B);
      else if (hdr_idx == HDR_SIG1) sig_good = sig_good && (b == SIG_M);
      else if (hdr_idx >= HDR_W0 && hdr_idx < HDR_W0 + 4) img_w[8*(hdr_idx-HDR_W0) +: 8] = b;
      else if (hdr_idx >= HDR_H0 && hdr_idx < HDR_H0 + 4) img_h[8*(hdr_idx-HDR_H0) +: 8] = b;
      else if (hdr_idx >= HDR_D0 && hdr_idx < HDR_D0 + 2)
        img_depth[8*(hdr_idx-HDR_D0) +: 8] = b;
      hdr_idx++;
      if (hdr_idx == HDR_BYTES) begin
        dec_phase = PH_IDLE;
        fin = 1'b1;
        if (!sig_good) outs.push_back(beat_of(KIND_BADSIG, '0, '0));
        else if (img_depth != DEPTH_24) outs.push_back(beat_of(KIND_BADDEPTH, '0, '0));
        else if (img_w[31] || img_w == 0 || img_h[31] || img_h == 0)
          outs.push_back(beat_of(KIND_DONE, '0, '0));
        else if (img_w > 32'hFFFF || img_h > 32'hFFFF)
          outs.push_back(beat_of(KIND_LARGE, '0, '0));
        else begin
          dec_phase = PH_PIXEL;
          fin = 1'b0;
        end
      end
    end else if (dec_phase == PH_PIXEL) begin
      if (pix_byte == 0) begin
        held_bg  = {8'h00, b};
        pix_byte = 1;
      end else if (pix_byte == 1) begin
        held_bg[15:8] = b;
        pix_byte = 2;
      end else begin
        xs = x_off + int'(col_idx);
        ys = y_off + int'(img_h) - 1 - int'(row_idx);
        pix_byte = 0;
        if (xs >= 0 && ys >= 0 && xs < SCR_W && ys < SCR_H) begin
          addr = 19'(ys * SCR_W + xs);
          outs.push_back(beat_of(KIND_PIXEL, addr, {ALPHA, b, held_bg}));
        end
        col_idx++;
        if (col_idx >= img_w) begin
          pad = ((img_w * 24 + 31) / 32) * 4 - img_w * 3;
          col_idx = 0;
          if (pad != 0) begin
            pad_cnt   = pad & 3;
            dec_phase = PH_PAD;
          end else begin
            fin = close_row();
          end
        end
      end
    end else begin
      if (pad_cnt > 0) pad_cnt--;
      if (pad_cnt == 0) fin = close_row();
    end
    if (fin) begin
      if (outs.size() == 0 || outs[outs.size()-1].kind == KIND_PIXEL)
        outs.push_back(beat_of(KIND_DONE, '0, '0));
    end else if (eof) begin
      outs.push_back(beat_of(KIND_TRUNC, '0, '0));
      dec_phase = PH_IDLE;
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) fb_q.push_back(outs[i]);
  endtask

  task automatic report_diff(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (fb_q.size() == 0) begin
        report_diff($sformatf("unexpected beat kind %0d addr %0d value %h last %0b",
                              res_if.kind, res_if.pixel_address, res_if.pixel_value,
                              res_if.last_of_run));
      end else begin
        head_beat = fb_q.pop_front();
        if (res_if.kind !== head_beat.kind || res_if.pixel_address !== head_beat.addr ||
            res_if.pixel_value !== head_beat.value ||
            res_if.last_of_run !== head_beat.last)
          report_diff($sformatf("beat got %0d/%0d/%h/%0b, want %0d/%0d/%h/%0b",
                                res_if.kind, res_if.pixel_address, res_if.pixel_value,
                                res_if.last_of_run, head_beat.kind, head_beat.addr,
                                head_beat.value, head_beat.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result back-pressure in bursts
  initial begin
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (!stalls_on) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic eof);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= b;
    byte_if.first_byte  <= first;
    byte_if.end_of_file <= eof;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_used++;
    decode_byte(b, first, eof);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    byte_if.valid <= 1'b0;
    while (fb_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_offsets(input logic [15:0] x, input logic [15:0] y);
    int k;
    for (k = 0; k < 2; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= (k == 0) ? CFG_X_OFFSET : CFG_Y_OFFSET;
      cfg_if.data  <= (k == 0) ? x : y;
      do @(posedge clk_i); while (!cfg_if.ready);
      if (k == 0) x_off = $signed(x);
      else y_off = $signed(y);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // header with the given fields, random filler and random pixel bytes after it
  task automatic send_file(input logic [31:0] w, input logic [31:0] h, input logic [15:0] depth,
                           input bit sig_ok, input int n_bytes, input bit eof_last,
                           input bit mark_first);
    logic [7:0] hdr[HDR_BYTES];
    logic [7:0] flip;
    logic [7:0] b;
    int         i;
    foreach (hdr[j]) hdr[j] = 8'($urandom_range(0, 255));
    hdr[HDR_SIG0] = SIG_B;
    hdr[HDR_SIG1] = SIG_M;
    if (!sig_ok) begin
      flip = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) hdr[HDR_SIG0] = SIG_B ^ flip;
      else hdr[HDR_SIG1] = SIG_M ^ flip;
    end
    for (i = 0; i < 4; i++) begin
      hdr[HDR_W0 + i] = w[8*i +: 8];
      hdr[HDR_H0 + i] = h[8*i +: 8];
    end
    hdr[HDR_D0]     = depth[7:0];
    hdr[HDR_D0 + 1] = depth[15:8];
    for (i = 0; i < n_bytes; i++) begin
      if (i < HDR_BYTES) b = hdr[i];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, mark_first && i == 0, eof_last && i == n_bytes - 1);
    end
  endtask

  task automatic random_offsets();
    int x;
    int y;
    case ($urandom_range(0, 4))
      0: begin
        x = $urandom_range(0, 20);
        y = $urandom_range(0, 20);
      end
      1: begin
        x = SCR_W - int'($urandom_range(0, 10));
        y = SCR_H - int'($urandom_range(0, 7));
      end
      2: begin
        x = -int'($urandom_range(0, 8));
        y = -int'($urandom_range(0, 5));
      end
      3: begin
        x = $urandom_range(0, 65535);
        y = $urandom_range(0, 65535);
      end
      default: begin
        x = $urandom_range(0, SCR_W - 1);
        y = $urandom_range(0, SCR_H - 1);
      end
    endcase
    set_offsets(x[15:0], y[15:0]);
  endtask

  task automatic test_small_images();
    // first file relies on the reset state, no first_byte
    send_file(2, 1, DEPTH_24, 1, image_bytes(2, 1), 1, 0);
    send_file(3, 2, DEPTH_24, 1, image_bytes(3, 2), 0, 1);
  endtask

  task automatic test_header_reports();
    send_file(4, 2, DEPTH_24, 0, HDR_BYTES, 1, 1);
    send_file(4, 2, 16'd32, 1, HDR_BYTES + 3, 1, 1);
    send_file(0, 2, DEPTH_24, 1, HDR_BYTES, 1, 1);
    send_file(3, 32'hFFFF_FFFF, DEPTH_24, 1, HDR_BYTES, 0, 1);
    send_file(32'h0001_0000, 1, DEPTH_24, 1, HDR_BYTES, 1, 1);
    send_file(2, 2, DEPTH_24, 1, 20, 1, 1);
    send_file(2, 2, DEPTH_24, 1, 1, 1, 1);
  endtask

  task automatic test_clipping();
    wait_results();
    set_offsets(16'(SCR_W - 2), 16'(SCR_H - 2));
    send_file(3, 3, DEPTH_24, 1, image_bytes(3, 3), 1, 1);
    wait_results();
    set_offsets(16'hFFFF, 16'hFFFF);
    send_file(2, 2, DEPTH_24, 1, image_bytes(2, 2), 1, 1);
    wait_results();
    set_offsets(16'd0, 16'd0);
  endtask

  task automatic test_truncation();
    send_file(3, 2, DEPTH_24, 1, HDR_BYTES + 3, 1, 1);
    send_file(1, 2, DEPTH_24, 1, HDR_BYTES + 4, 1, 1);
    // abandoned mid-image, restarted by first_byte
    send_file(2, 2, DEPTH_24, 1, HDR_BYTES + 7, 0, 1);
    send_file(32'hFFFF, 32'hFFFF, DEPTH_24, 1, HDR_BYTES + 9, 1, 1);
  endtask

  task automatic test_idle_bytes();
    int i;
    send_file(1, 1, DEPTH_24, 1, image_bytes(1, 1) + 5, 1, 1);
    for (i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)), 1'b0, i == 5);
  endtask

  task automatic test_random_files();
    int          sel;
    int unsigned w;
    int unsigned h;
    int          len;
    logic [15:0] d;
    int          i;
    stalls_on = 1'b1;
    while (bytes_used < BYTE_BUDGET) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_results();
        random_offsets();
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 5);
      end
      len = image_bytes(w, h);
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_file(w, h, DEPTH_24, 1, len, 1, 1);
      end else if (sel < 75) begin
        send_file(w, h, DEPTH_24, 1, $urandom_range(1, len - 1), 1, 1);
      end else if (sel < 80) begin
        send_file(w, h, DEPTH_24, 1, $urandom_range(1, len - 1), 0, 1);
      end else if (sel < 86) begin
        send_file(w, h, DEPTH_24, 1, len + $urandom_range(1, 4), 1'($urandom_range(0, 1)), 1);
      end else if (sel < 90) begin
        send_file(w, h, DEPTH_24, 1, len, 0, 1);
      end else if (sel < 95) begin
        case ($urandom_range(0, 3))
          0: send_file(w, h, DEPTH_24, 0, HDR_BYTES + $urandom_range(0, 3),
                       1'($urandom_range(0, 1)), 1);
          1: begin
            d = 16'($urandom_range(0, 65535));
            if (d == DEPTH_24) d = DEPTH_24 + 16'd1;
            send_file(w, h, d, 1, HDR_BYTES + $urandom_range(0, 3),
                      1'($urandom_range(0, 1)), 1);
          end
          2: send_file(w, 32'h8000_0000 | $urandom, DEPTH_24, 1, HDR_BYTES, 1, 1);
          default: send_file($urandom_range(65536, 200000), h, DEPTH_24, 1, HDR_BYTES, 1, 1);
        endcase
      end else begin
        for (i = $urandom_range(1, 16); i > 0; i--)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic test_steady_stream();
    int i;
    int unsigned w;
    int unsigned h;
    wait_results();
    gap_pct   = 0;
    stalls_on = 1'b0;
    set_offsets(16'd100, 16'd50);
    for (i = 0; i < 2; i++) begin
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 2);
      send_file(w, h, DEPTH_24, 1, image_bytes(w, h), 1, 1);
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    byte_if.valid         = 1'b0;
    byte_if.data_byte     = '0;
    byte_if.first_byte    = 1'b0;
    byte_if.end_of_file   = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_X_OFFSET;
    cfg_if.data           = '0;
    err_count             = 0;
    bytes_used            = 0;
    idle_cycles           = 0;
    gap_pct               = 15;
    stalls_on             = 1'b1;
    x_off                 = 0;
    y_off                 = 0;
    clear_parser();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_small_images();
    test_header_reports();
    test_clipping();
    test_truncation();
    test_idle_bytes();
    test_random_files();
    test_steady_stream();
    wait_results();
    repeat (8) @(negedge clk_i);
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
